FILE: hw/rtl/bcf_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// bcf_pkg
// Types, register indexes and helper functions for the beat color fade block.
// -----------------------------------------------------------------------------
package bcf_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned FaderW  = 7;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned NFader  = 3;
  localparam int unsigned DataW   = 3 * ChanW;
  localparam int unsigned UserW   = 2;

  // tuser bit positions
  localparam int unsigned UserMode = 0;
  localparam int unsigned UserBeat = 1;

  // fader slots
  localparam int unsigned FSecond = 0;
  localparam int unsigned FMax    = 1;
  localparam int unsigned FThird  = 2;

  localparam logic [31:0] SeedWord = 32'h2545_F491;

  typedef logic signed [FaderW-1:0] fader_t;
  typedef logic [ChanW-1:0]         chan_t;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_SECOND = 3'd0,
    CFG_TARGET_MAX    = 3'd1,
    CFG_TARGET_THIRD  = 3'd2,
    CFG_BEAT_SECOND   = 3'd3,
    CFG_BEAT_MAX      = 3'd4,
    CFG_BEAT_THIRD    = 3'd5,
    CFG_ON_BEAT_EN    = 3'd6,
    CFG_ON_BEAT_RAND  = 3'd7
  } cfg_idx_e;

  // One xorshift32 step, shifts 13, 17, 5.
  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  // Move one unit toward the target, stay when equal.
  function automatic fader_t glide(input fader_t cur, input fader_t tgt);
    if (cur < tgt) begin
      return cur + fader_t'(1);
    end else if (cur > tgt) begin
      return cur - fader_t'(1);
    end
    return cur;
  endfunction

  // Add a signed offset to a channel and clamp to 0..255.
  function automatic chan_t add_clamp(input chan_t chan, input fader_t off);
    logic signed [ChanW+1:0] s;
    s = $signed({2'b00, chan}) + (ChanW+2)'(off);
    if (s < 0) begin
      return '0;
    end else if (s > $signed((ChanW+2)'(255))) begin
      return '1;
    end
    return s[ChanW-1:0];
  endfunction

endpackage : bcf_pkg
`default_nettype wire

FILE: hw/rtl/beat_color_fade.sv
`default_nettype none
// -----------------------------------------------------------------------------
// beat_color_fade
// Dominant-channel color offset with beat-driven faders, 3-stage pipeline.
// -----------------------------------------------------------------------------
// Path: a pixel beat passes three register stages, the output register last.
// A stall on m_axis holds the output register; a stage takes new data when
//   empty or when the next one advances. Throughput: one beat per cycle
//   without a stall, pixels and frame ticks alike; the fader update for a
//   tick is done in the cycle the tick is accepted.
// Reset: faders cleared, configuration registers cleared, random word set to
//   its seed, pipeline emptied.
// -----------------------------------------------------------------------------
module beat_color_fade
  import bcf_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,

  input  wire logic               s_axis_tvalid,
  output logic                    s_axis_tready,
  input  wire logic [DataW-1:0]   s_axis_tdata,   // in_red, in_green, in_blue
  input  wire logic [UserW-1:0]   s_axis_tuser,   // mode, beat

  output logic                    m_axis_tvalid,
  input  wire logic               m_axis_tready,
  output logic [DataW-1:0]        m_axis_tdata,   // out_red, out_green, out_blue

  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [FaderW-1:0]  cfg_data_i
);

  // ---------------------------------------------------------------------------
  // Config regs, always ready. User must write only while idle; not enforced.
  // ---------------------------------------------------------------------------
  fader_t [NFader-1:0] target_q;
  fader_t [NFader-1:0] beat_val_q;
  logic                on_beat_en_q;
  logic                on_beat_rand_q;
  logic                cfg_fire;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q       <= '0;
      beat_val_q     <= '0;
      on_beat_en_q   <= 1'b0;
      on_beat_rand_q <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_TARGET_SECOND: target_q[FSecond]   <= cfg_data_i;
        CFG_TARGET_MAX:    target_q[FMax]      <= cfg_data_i;
        CFG_TARGET_THIRD:  target_q[FThird]    <= cfg_data_i;
        CFG_BEAT_SECOND:   beat_val_q[FSecond] <= cfg_data_i;
        CFG_BEAT_MAX:      beat_val_q[FMax]    <= cfg_data_i;
        CFG_BEAT_THIRD:    beat_val_q[FThird]  <= cfg_data_i;
        CFG_ON_BEAT_EN:    on_beat_en_q        <= cfg_data_i[0];
        CFG_ON_BEAT_RAND:  on_beat_rand_q      <= cfg_data_i[0];
        default:           on_beat_en_q        <= on_beat_en_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline handshake: each stage advances when empty or when the next one
  // advances. The output register is the last stage.
  // ---------------------------------------------------------------------------
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic adv_out, adv_s2, adv_s1;
  logic in_fire, tick_fire, pix_fire;
  logic in_mode, in_beat;

  assign adv_out = ~out_valid_q | m_axis_tready;
  assign adv_s2  = ~s2_valid_q | adv_out;
  assign adv_s1  = ~s1_valid_q | adv_s2;

  assign s_axis_tready = adv_s1;
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign in_mode       = s_axis_tuser[UserMode];
  assign in_beat       = s_axis_tuser[UserBeat];
  assign tick_fire     = in_fire & in_mode;
  assign pix_fire      = in_fire & ~in_mode;

  // ---------------------------------------------------------------------------
  // Fader update on a frame tick. Pixels accepted later see the new values;
  // a pixel snapshots the faders when it enters stage 1.
  // ---------------------------------------------------------------------------
  fader_t [NFader-1:0] fader_q, fader_d;
  logic [31:0]         rand_q, rand_d;
  logic [31:0]         draw1, draw2, draw3;
  fader_t              rnd_max;
  logic [5:0]          max_bits;

  always_comb begin
    draw1    = xorshift32(rand_q);
    draw2    = xorshift32(draw1);
    draw3    = xorshift32(draw2);
    max_bits = draw2[5:0];

    // mod 64 minus 32, then push the small magnitudes out to full swing
    rnd_max = fader_t'({1'b0, max_bits}) - fader_t'(32);
    if (max_bits > 6'd16 && max_bits < 6'd32) begin
      rnd_max = fader_t'(-32);
    end else if (max_bits >= 6'd32 && max_bits < 6'd48) begin
      rnd_max = fader_t'(32);
    end

    fader_d = fader_q;
    rand_d  = rand_q;
    if (tick_fire) begin
      for (int i = 0; i < NFader; i++) begin
        fader_d[i] = glide(fader_q[i], target_q[i]);
      end
      if (!on_beat_en_q) begin
        fader_d = target_q;
      end else if (in_beat && on_beat_rand_q) begin
        fader_d[FSecond] = fader_t'({2'b00, draw1[4:0]}) - fader_t'(6);
        fader_d[FMax]    = rnd_max;
        fader_d[FThird]  = fader_t'({2'b00, draw3[4:0]}) - fader_t'(6);
        rand_d           = draw3;
      end else if (in_beat) begin
        fader_d = beat_val_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fader_q <= '0;
      rand_q  <= SeedWord;
    end else begin
      fader_q <= fader_d;
      rand_q  <= rand_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: register the pixel and a snapshot of the faders.
  // ---------------------------------------------------------------------------
  chan_t               s1_r_q, s1_g_q, s1_b_q;
  fader_t [NFader-1:0] s1_fader_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (adv_s1) begin
      s1_valid_q <= pix_fire;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s1 && pix_fire) begin
      s1_r_q     <= s_axis_tdata[ChanW-1:0];
      s1_g_q     <= s_axis_tdata[2*ChanW-1:ChanW];
      s1_b_q     <= s_axis_tdata[3*ChanW-1:2*ChanW];
      s1_fader_q <= fader_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: find the dominant channel and pick the offset row.
  // Ties fall back to the third fader on all channels.
  // ---------------------------------------------------------------------------
  fader_t s2_off_r_d, s2_off_g_d, s2_off_b_d;
  fader_t s2_off_r_q, s2_off_g_q, s2_off_b_q;
  chan_t  s2_r_q, s2_g_q, s2_b_q;

  always_comb begin
    if (s1_g_q > s1_b_q && s1_g_q > s1_r_q) begin
      s2_off_r_d = s1_fader_q[FThird];
      s2_off_g_d = s1_fader_q[FMax];
      s2_off_b_d = s1_fader_q[FSecond];
    end else if (s1_r_q > s1_b_q && s1_r_q > s1_g_q) begin
      s2_off_r_d = s1_fader_q[FMax];
      s2_off_g_d = s1_fader_q[FSecond];
      s2_off_b_d = s1_fader_q[FThird];
    end else if (s1_b_q > s1_g_q && s1_b_q > s1_r_q) begin
      s2_off_r_d = s1_fader_q[FSecond];
      s2_off_g_d = s1_fader_q[FThird];
      s2_off_b_d = s1_fader_q[FMax];
    end else begin
      s2_off_r_d = s1_fader_q[FThird];
      s2_off_g_d = s1_fader_q[FThird];
      s2_off_b_d = s1_fader_q[FThird];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (adv_s2) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s2 && s1_valid_q) begin
      s2_r_q     <= s1_r_q;
      s2_g_q     <= s1_g_q;
      s2_b_q     <= s1_b_q;
      s2_off_r_q <= s2_off_r_d;
      s2_off_g_q <= s2_off_g_d;
      s2_off_b_q <= s2_off_b_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: add offsets, clamp, and hold in the output register.
  // ---------------------------------------------------------------------------
  logic [DataW-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv_out) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && s2_valid_q) begin
      out_data_q <= {add_clamp(s2_b_q, s2_off_b_q),
                     add_clamp(s2_g_q, s2_off_g_q),
                     add_clamp(s2_r_q, s2_off_r_q)};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // the random word never collapses to the xorshift fixed point
  assert property (@(posedge clk_i) disable iff (!rst_ni) rand_q != '0)
    else $error("random word reached zero");

  // a tick with beat reaction off lands every fader on its target
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_fire && !on_beat_en_q |=> fader_q == $past(target_q))
    else $error("fader missed target with beat reaction off");

  // an accepted pixel enters stage 1, a tick never does
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> s1_valid_q == !$past(in_mode))
    else $error("stage 1 valid does not follow accepted item kind");

  // random word only moves on a random beat tick
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(tick_fire && on_beat_en_q && on_beat_rand_q && in_beat) |=> $stable(rand_q))
    else $error("random word advanced without a random beat");

endmodule : beat_color_fade
`default_nettype wire
